// ===== src/smeu_pkg.sv =====
// Package for the stack machine execute unit: sizes, opcodes, status codes,
// sequencer states and the shared ALU request type. No dependencies.
package smeu_pkg;

   localparam int STACK_DEPTH  = 64;
   localparam int NUM_REGS     = 4;
   localparam int RETURN_DEPTH = 16;
   localparam int POS_BITS     = 16;

   localparam int SP_BITS  = $clog2(STACK_DEPTH);
   localparam int SC_BITS  = $clog2(STACK_DEPTH + 1);
   localparam int RP_BITS  = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
   localparam int RC_BITS  = $clog2(RETURN_DEPTH + 1);
   localparam int REG_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   typedef enum logic [4:0] {
      OP_PUSHR = 5'd0,  OP_POPR = 5'd1,  OP_RET = 5'd2,  OP_CALL = 5'd3,
      OP_JMP   = 5'd4,  OP_JEQ  = 5'd5,  OP_JNE = 5'd6,  OP_JA   = 5'd7,
      OP_JAE   = 5'd8,  OP_JB   = 5'd9,  OP_JBE = 5'd10, OP_PUSH = 5'd11,
      OP_POP   = 5'd12, OP_ADD  = 5'd13, OP_SUB = 5'd14, OP_MUL  = 5'd15,
      OP_DIV   = 5'd16, OP_OUT  = 5'd17, OP_IN  = 5'd18
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_UNDERFLOW = 3'd1, ST_OVERFLOW = 3'd2, ST_RET_UNDER = 3'd3,
      ST_RET_OVER = 3'd4, ST_DIV_ZERO = 3'd5, ST_BAD_OP = 3'd6, ST_BAD_TARGET = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ_TOP, S_READ_BELOW, S_EXEC, S_ALU_WAIT, S_DONE
   } state_type;

   // Handshake between the sequencer and the shared arithmetic unit.
   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } alu_rsp_type;

endpackage

// ===== src/smeu_alu.sv =====
// Shared multi-cycle multiply/divide unit: shift-add multiply and
// restoring divide, one bit per cycle. Uses smeu_pkg.
module smeu_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  smeu_pkg::alu_req_type req,
   output smeu_pkg::alu_rsp_type rsp
);
   import smeu_pkg::*;

   logic        busy_ff, busy_in;
   logic        div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] opa_ff, opa_in;
   logic [31:0] opb_ff, opb_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] rem_sh;

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      done_in = 1'b0;
      rem_sh  = {acc_ff[30:0], opa_ff[31]};
      trial   = {1'b0, rem_sh} - {1'b0, opb_ff};
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         div_in  = req.is_div;
         cnt_in  = 6'd0;
         acc_in  = 32'd0;
         // Division works on magnitudes and fixes the sign at the end.
         neg_in  = req.is_div & (req.a[31] ^ req.b[31]);
         opa_in  = (req.is_div && req.a[31]) ? 32'd0 - req.a : req.a;
         opb_in  = (req.is_div && req.b[31]) ? 32'd0 - req.b : req.b;
      end else if (busy_ff) begin
         if (div_ff) begin
            // Quotient bits shift into opa from the bottom.
            if (!trial[32]) begin
               acc_in = trial[31:0];
               opa_in = {opa_ff[30:0], 1'b1};
            end else begin
               acc_in = rem_sh;
               opa_in = {opa_ff[30:0], 1'b0};
            end
         end else begin
            acc_in = acc_ff + (opb_ff[0] ? opa_ff : 32'd0);
            opa_in = {opa_ff[30:0], 1'b0};
            opb_in = {1'b0, opb_ff[31:1]};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = div_ff ? (neg_ff ? 32'd0 - opa_ff : opa_ff) : acc_ff;

   always_ff @(posedge clock) begin
      if (!reset && done_ff) begin
         assert (!busy_ff) else $error("alu done while still busy");
      end
   end
   assert property (@(posedge clock) disable iff (reset)
      req.start && !busy_ff |=> busy_ff) else $error("alu failed to start");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff == 6'd31 |=> done_ff && !busy_ff)
      else $error("alu did not finish after 32 steps");
   assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("alu done held two cycles");

endmodule

// ===== src/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit: sequencer, data and return
// stack memories, register file. Uses smeu_pkg and smeu_alu.
// The result is registered after two registered reads of the data stack
// memory and the execute state; mul and div also wait on the shared
// bit-serial unit. A new instruction is not accepted until the result has
// been taken: req_tready is high only when idle.
// Reset clears counts, registers and control; stack memories are not cleared.
module stack_machine_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[4:0], reg_index[6:5], immediate[38:7], position[54:39],
   // in_value[86:55], zero fill [87]
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_position[15:0], taken[16], out_value[48:17], out_valid[49],
   // status[52:50], zero fill [55:53]
   output logic [55:0] rsp_tdata
);
   import smeu_pkg::*;

   state_type state_ff, state_in;

   logic [31:0] dstack [STACK_DEPTH];
   logic [POS_BITS-1:0] rstack [RETURN_DEPTH];
   logic [31:0] regs_ff [NUM_REGS];

   logic [SC_BITS-1:0] sc_ff, sc_in;
   logic [RC_BITS-1:0] rc_ff, rc_in;
   logic [15:0]        depth_ff, depth_in;

   logic [4:0]  op_ff;
   logic [REG_BITS-1:0] ri_ff;
   logic [31:0] imm_ff, inv_ff;
   logic [POS_BITS-1:0] pos_ff;
   logic [31:0] top_ff, below_ff, rd_ff;
   logic [POS_BITS-1:0] rrd_ff;

   logic [15:0] nxt_ff, nxt_in;
   logic        tk_ff, tk_in, ov_ff, ov_in;
   logic [31:0] oval_ff, oval_in;
   logic [2:0]  st_ff, st_in;

   logic                d_we, r_we, g_we;
   logic [SP_BITS-1:0]  d_wa, d_ra;
   logic [31:0]         d_wd;
   logic [RP_BITS-1:0]  r_wa, r_ra;
   logic [POS_BITS-1:0] r_wd;
   logic [31:0]         g_wd;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   smeu_alu u_alu (.clock(clock), .reset(reset), .req(alu_req), .rsp(alu_rsp));

   logic        is_jump, bad_target, cond;
   logic signed [31:0] st_s, sb_s;
   status_type  chk;

   assign is_jump = (op_ff >= OP_CALL) && (op_ff <= OP_JBE);
   assign bad_target = imm_ff[31] ||
      ((POS_BITS < 31) && ((imm_ff >> POS_BITS) != 32'd0));
   assign st_s = top_ff;
   assign sb_s = below_ff;

   always_comb begin
      chk = ST_OK;
      if (op_ff > OP_IN) chk = ST_BAD_OP;
      else if (is_jump && bad_target) chk = ST_BAD_TARGET;
      else if ((op_ff == OP_PUSHR || op_ff == OP_PUSH || op_ff == OP_IN) &&
               sc_ff >= SC_BITS'(STACK_DEPTH)) chk = ST_OVERFLOW;
      else if ((op_ff == OP_POPR || op_ff == OP_POP || op_ff == OP_OUT) &&
               sc_ff == '0) chk = ST_UNDERFLOW;
      else if (((op_ff >= OP_JEQ && op_ff <= OP_JBE) ||
                (op_ff >= OP_ADD && op_ff <= OP_DIV)) &&
               sc_ff < SC_BITS'(2)) chk = ST_UNDERFLOW;
      else if (op_ff == OP_RET && rc_ff == '0) chk = ST_RET_UNDER;
      else if (op_ff == OP_CALL && rc_ff >= RC_BITS'(RETURN_DEPTH)) chk = ST_RET_OVER;
      else if (op_ff == OP_DIV && top_ff == 32'd0) chk = ST_DIV_ZERO;
   end

   always_comb begin
      case (op_ff)
         OP_JEQ:  cond = st_s == sb_s;
         OP_JNE:  cond = st_s != sb_s;
         OP_JA:   cond = st_s > sb_s;
         OP_JAE:  cond = st_s >= sb_s;
         OP_JB:   cond = st_s < sb_s;
         OP_JBE:  cond = st_s <= sb_s;
         default: cond = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      sc_in = sc_ff; rc_in = rc_ff; depth_in = depth_ff;
      nxt_in = nxt_ff; tk_in = tk_ff; ov_in = ov_ff; oval_in = oval_ff; st_in = st_ff;
      d_we = 1'b0; d_wa = sc_ff[SP_BITS-1:0]; d_wd = top_ff;
      d_ra = SP_BITS'(sc_ff - SC_BITS'(1));
      r_we = 1'b0; r_wa = rc_ff[RP_BITS-1:0]; r_wd = pos_ff;
      r_ra = RP_BITS'(rc_ff - RC_BITS'(1));
      g_we = 1'b0; g_wd = top_ff;
      alu_req = '0;
      alu_req.a = below_ff;
      alu_req.b = top_ff;
      alu_req.is_div = (op_ff == OP_DIV);
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = S_READ_TOP;
         end
         S_READ_TOP: begin
            d_ra = SP_BITS'(sc_ff - SC_BITS'(2));
            state_in = S_READ_BELOW;
         end
         S_READ_BELOW: state_in = S_EXEC;
         S_EXEC: begin
            nxt_in = 16'(pos_ff); tk_in = 1'b0; ov_in = 1'b0; oval_in = 32'd0;
            st_in = chk;
            state_in = S_DONE;
            if (chk == ST_OK) begin
               case (op_ff)
                  OP_PUSHR: begin
                     d_we = 1'b1; d_wd = regs_ff[ri_ff]; sc_in = sc_ff + SC_BITS'(1);
                  end
                  OP_POPR: begin
                     g_we = 1'b1; sc_in = sc_ff - SC_BITS'(1);
                  end
                  OP_RET: begin
                     rc_in = rc_ff - RC_BITS'(1);
                     nxt_in = 16'(rrd_ff); tk_in = 1'b1;
                     depth_in = depth_ff - 16'd1;
                  end
                  OP_CALL: begin
                     r_we = 1'b1; rc_in = rc_ff + RC_BITS'(1);
                     nxt_in = imm_ff[15:0]; tk_in = 1'b1;
                     depth_in = depth_ff + 16'd1;
                  end
                  OP_JMP: begin
                     nxt_in = imm_ff[15:0]; tk_in = 1'b1;
                  end
                  OP_PUSH: begin
                     d_we = 1'b1; d_wd = imm_ff; sc_in = sc_ff + SC_BITS'(1);
                  end
                  OP_IN: begin
                     d_we = 1'b1; d_wd = inv_ff; sc_in = sc_ff + SC_BITS'(1);
                  end
                  OP_POP: sc_in = sc_ff - SC_BITS'(1);
                  OP_ADD, OP_SUB: begin
                     d_we = 1'b1; d_wa = SP_BITS'(sc_ff - SC_BITS'(2));
                     d_wd = (op_ff == OP_ADD) ? below_ff + top_ff : below_ff - top_ff;
                     sc_in = sc_ff - SC_BITS'(1);
                  end
                  OP_MUL, OP_DIV: begin
                     alu_req.start = 1'b1;
                     state_in = S_ALU_WAIT;
                  end
                  OP_OUT: begin
                     sc_in = sc_ff - SC_BITS'(1); ov_in = 1'b1; oval_in = top_ff;
                  end
                  default: begin
                     if (cond) begin
                        nxt_in = imm_ff[15:0]; tk_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_ALU_WAIT: begin
            if (alu_rsp.done) begin
               d_we = 1'b1; d_wa = SP_BITS'(sc_ff - SC_BITS'(2));
               d_wd = alu_rsp.result;
               sc_in = sc_ff - SC_BITS'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sc_ff <= '0; rc_ff <= '0; depth_ff <= '0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= 32'd0;
      end else begin
         state_ff <= state_in;
         sc_ff <= sc_in; rc_ff <= rc_in; depth_ff <= depth_in;
         if (g_we) regs_ff[ri_ff] <= g_wd;
      end
      nxt_ff <= nxt_in; tk_ff <= tk_in; ov_ff <= ov_in;
      oval_ff <= oval_in; st_ff <= st_in;
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff  <= req_tdata[4:0];
         ri_ff  <= REG_BITS'(req_tdata[6:5] % NUM_REGS);
         imm_ff <= req_tdata[38:7];
         pos_ff <= POS_BITS'(req_tdata[54:39]);
         inv_ff <= req_tdata[86:55];
      end
   end

   // Data and return stack memories with registered reads. The top word is
   // read while idle and the word below it in the first read state.
   always_ff @(posedge clock) begin
      if (d_we) dstack[d_wa] <= d_wd;
      rd_ff <= dstack[d_ra];
      if (r_we) rstack[r_wa] <= r_wd;
      rrd_ff <= rstack[r_ra];
      if (state_ff == S_READ_TOP) top_ff <= rd_ff;
      if (state_ff == S_READ_BELOW) below_ff <= rd_ff;
   end

   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata  = {3'd0, st_ff, ov_ff, oval_ff, tk_ff, nxt_ff};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepting while result pending");
   assert property (@(posedge clock) disable iff (reset)
      sc_ff <= SC_BITS'(STACK_DEPTH)) else $error("stack count out of range");
   assert property (@(posedge clock) disable iff (reset)
      rc_ff <= RC_BITS'(RETURN_DEPTH)) else $error("return count out of range");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff != ST_OK |-> !tk_ff && !ov_ff)
      else $error("faulting instruction changed flow or output");

endmodule
